>>> hdl/ncd_pkg.sv
// Shared types, constants and helpers for the NMEA coordinate to degrees unit.
`timescale 1ns / 1ps

package ncd_pkg;

  // Parser phase codes
  localparam logic [1:0] PH_INT  = 2'd0;
  localparam logic [1:0] PH_FRAC = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] DEG_SCALE  = 32'd10000000;
  localparam logic [26:0] MIN_SCALE  = 27'd1000000;
  localparam logic [26:0] FRAC_SCALE = 27'd100;
  // ceil(2^33 / 3): (y * RECIP_3) >> 33 == y / 3 for any y below 2^32
  localparam logic [57:0] RECIP_3    = 58'h0AAAAAAAB;
  localparam int          RECIP_SHIFT = 33;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  typedef struct packed {
    logic [31:0] degrees_e7;
    logic        too_long;
  } result_t;

  // One finished field, handed from the parser to the arithmetic pipeline
  typedef struct packed {
    logic        overflow;
    logic [7:0]  degrees;
    logic [6:0]  minutes;
    logic [13:0] fraction;
    logic [2:0]  fraction_digits;
  } field_t;

  // Scale that pads the fractional minutes out to four places
  function automatic logic [13:0] pad_scale(input logic [2:0] digits);
    logic [13:0] scale;
    case (digits)
      3'd0:    scale = 14'd10000;
      3'd1:    scale = 14'd1000;
      3'd2:    scale = 14'd100;
      3'd3:    scale = 14'd10;
      default: scale = 14'd1;
    endcase
    return scale;
  endfunction

endpackage

>>> hdl/nmea_coordinate_to_degrees_unit.sv
// Top level of the NMEA coordinate (ddmm.mmmm) to 1e-7 degree converter.
//
// Usage:
//   chars channel (chars_valid / chars_ready / chars): one ASCII character of
//   the coordinate field per beat; chars.last marks the final character.
//   result channel (result_valid / result_ready / result): one beat per field,
//   degrees_e7 = degrees*10^7 + minutes*10^7/60, and too_long when the integer
//   part ran past MAX_INTEGER_DIGITS digits (degrees_e7 is then 0).
// Throughput: one character per cycle while the queue is not full, including
//   back-to-back fields; one result per cycle at most.
// Path: parser -> queue -> three multiply stages -> output reg; each step is
//   registered, and a low result_ready can hold a field between them.
// Structure: the parser updates its state once per accepted character and
//   drops each finished field into a 4-entry queue; the arithmetic pipeline
//   drains the queue independently.
// Stall: when result_ready is low the pipeline fills, then the queue; once
//   the queue holds 4 fields chars_ready drops until a result beat leaves.
// Reset: rst (synchronous) empties the queue and pipeline and returns the
//   parser to the start of a field.
`timescale 1ns / 1ps

module nmea_coordinate_to_degrees_unit #(
  parameter int MAX_INTEGER_DIGITS = 15,
  parameter int FRACTION_DIGITS    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                chars_valid,
  output logic                chars_ready,
  input  ncd_pkg::char_beat_t chars,
  output logic                result_valid,
  input  logic                result_ready,
  output ncd_pkg::result_t    result
);

  localparam int FIELD_W = $bits(ncd_pkg::field_t);

  logic             queue_push;
  logic             queue_full;
  logic             queue_pop;
  logic             queue_not_empty;
  ncd_pkg::field_t  push_field;
  ncd_pkg::field_t  head_field;
  logic [FIELD_W-1:0] head_bits;

  ncd_front #(
    .MAX_INTEGER_DIGITS(MAX_INTEGER_DIGITS),
    .FRACTION_DIGITS   (FRACTION_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .chars_valid(chars_valid),
    .chars_ready(chars_ready),
    .chars      (chars),
    .queue_full (queue_full),
    .push       (queue_push),
    .push_field (push_field)
  );

  // decouples the parser from the arithmetic pipeline
  ncd_queue #(
    .WIDTH(FIELD_W),
    .DEPTH(ncd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (queue_push),
    .push_data(push_field),
    .full     (queue_full),
    .pop      (queue_pop),
    .not_empty(queue_not_empty),
    .head     (head_bits)
  );

  assign head_field = ncd_pkg::field_t'(head_bits);

  ncd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .field_valid (queue_not_empty),
    .field       (head_field),
    .field_pop   (queue_pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // a field enters the queue only on an accepted last beat
  a_push_on_last: assert property (@(posedge clk) disable iff (rst)
    queue_push |-> (chars_valid && chars_ready && chars.last))
    else $error("field queued without an accepted last beat");

  // overflowed fields report zero
  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.too_long) |-> (result.degrees_e7 == 32'd0))
    else $error("too_long result with nonzero value");

  // largest reachable value is 255 degrees plus 99.9999 minutes
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.degrees_e7 <= 32'd2566666650))
    else $error("result out of range");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

>>> hdl/ncd_front.sv
// Character parser: accumulates one coordinate field and emits it on the last beat.
`timescale 1ns / 1ps

module ncd_front #(
  parameter int MAX_INTEGER_DIGITS = 15,
  parameter int FRACTION_DIGITS    = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               chars_valid,
  output logic               chars_ready,
  input  ncd_pkg::char_beat_t chars,
  input  logic               queue_full,
  output logic               push,
  output ncd_pkg::field_t    push_field
);

  localparam int CW = $clog2(MAX_INTEGER_DIGITS + 1);
  localparam int FW = $clog2(FRACTION_DIGITS + 1);

  logic [1:0]    phase, phase_next;
  logic [CW-1:0] int_count, int_count_next;
  logic [7:0]    held, held_next;
  logic [7:0]    deg_acc, deg_acc_next;
  logic [13:0]   frac_acc, frac_acc_next;
  logic [FW-1:0] frac_count, frac_count_next;
  logic          overflow, overflow_next;

  logic       is_digit;
  logic [3:0] digit;
  logic       accept;
  logic [6:0] minutes;

  assign chars_ready = !queue_full;
  assign accept      = chars_valid && chars_ready;
  assign is_digit    = (chars.character >= ncd_pkg::CHAR_ZERO) &&
                       (chars.character <= ncd_pkg::CHAR_NINE);
  assign digit       = chars.character[3:0];

  always_comb begin
    phase_next      = phase;
    int_count_next  = int_count;
    held_next       = held;
    deg_acc_next    = deg_acc;
    frac_acc_next   = frac_acc;
    frac_count_next = frac_count;
    overflow_next   = overflow;
    case (phase)
      ncd_pkg::PH_INT: begin
        if (is_digit) begin
          if (!overflow) begin
            if (int_count >= CW'(MAX_INTEGER_DIGITS)) begin
              overflow_next = 1'b1;
            end else begin
              if (int_count >= CW'(2)) begin
                deg_acc_next = 8'(12'(deg_acc) * 12'd10 + 12'(held[7:4]));
              end
              held_next      = {held[3:0], digit};
              int_count_next = int_count + CW'(1);
            end
          end
        end else if (overflow) begin
          phase_next = ncd_pkg::PH_DONE;
        end else if (chars.character == ncd_pkg::CHAR_DOT) begin
          phase_next = ncd_pkg::PH_FRAC;
        end else begin
          phase_next = ncd_pkg::PH_DONE;
        end
      end
      ncd_pkg::PH_FRAC: begin
        if (is_digit && (frac_count < FW'(FRACTION_DIGITS))) begin
          frac_acc_next   = 14'(frac_acc * 14'd10 + 14'(digit));
          frac_count_next = frac_count + FW'(1);
        end else begin
          phase_next = ncd_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // whole minutes are the last one or two integer digits
  always_comb begin
    if (int_count_next == CW'(0)) begin
      minutes = 7'd0;
    end else if (int_count_next == CW'(1)) begin
      minutes = 7'(held_next[3:0]);
    end else begin
      minutes = 7'(held_next[7:4]) * 7'd10 + 7'(held_next[3:0]);
    end
  end

  assign push                       = accept && chars.last;
  assign push_field.overflow        = overflow_next;
  assign push_field.degrees         = deg_acc_next;
  assign push_field.minutes         = minutes;
  assign push_field.fraction        = frac_acc_next;
  assign push_field.fraction_digits = 3'(frac_count_next);

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase      <= ncd_pkg::PH_INT;
      int_count  <= '0;
      held       <= '0;
      deg_acc    <= '0;
      frac_acc   <= '0;
      frac_count <= '0;
      overflow   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      int_count  <= int_count_next;
      held       <= held_next;
      deg_acc    <= deg_acc_next;
      frac_acc   <= frac_acc_next;
      frac_count <= frac_count_next;
      overflow   <= overflow_next;
    end
  end

endmodule

>>> hdl/ncd_queue.sv
// Small register FIFO between the parser and the arithmetic pipeline.
`timescale 1ns / 1ps

module ncd_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != CW'(0));
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/ncd_back.sv
// Arithmetic pipeline: scales a parsed field to 1e-7 degree and holds the result.
`timescale 1ns / 1ps

module ncd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              field_valid,
  input  ncd_pkg::field_t   field,
  output logic              field_pop,
  output logic              result_valid,
  input  logic              result_ready,
  output ncd_pkg::result_t  result
);

  logic        v1, v2, v3, v4;
  logic        rdy1, rdy2, rdy3, rdy4;

  // stage 1: two constant products and the fraction padding product
  logic        ovf1;
  logic [31:0] deg1;
  logic [26:0] min1;
  logic [13:0] frac1;
  // stage 2: numerator of the minutes term
  logic        ovf2;
  logic [31:0] deg2;
  logic [26:0] sum2;
  // stage 3: reciprocal multiply for the divide by three
  logic        ovf3;
  logic [31:0] deg3;
  logic [57:0] prod3;
  logic [25:0] half2;
  logic [24:0] minutes_e7;

  assign rdy4      = !v4 || result_ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign field_pop = field_valid && rdy1;

  assign half2      = sum2[26:1];
  assign minutes_e7 = prod3[57:ncd_pkg::RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ovf1  <= field.overflow;
      deg1  <= 32'(field.degrees) * ncd_pkg::DEG_SCALE;
      min1  <= 27'(field.minutes) * ncd_pkg::MIN_SCALE;
      frac1 <= 14'(field.fraction * ncd_pkg::pad_scale(field.fraction_digits));
    end
    if (rdy2) begin
      ovf2 <= ovf1;
      deg2 <= deg1;
      sum2 <= min1 + 27'(frac1) * ncd_pkg::FRAC_SCALE;
    end
    if (rdy3) begin
      ovf3  <= ovf2;
      deg3  <= deg2;
      prod3 <= 58'(half2) * ncd_pkg::RECIP_3;
    end
    if (rdy4) begin
      result.too_long   <= ovf3;
      result.degrees_e7 <= ovf3 ? 32'd0 : deg3 + 32'(minutes_e7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= field_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  assign result_valid = v4;

endmodule
